/* design/assert_macros.svh */
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) else $error(msg);

`endif

/* design/wsfr_pkg.sv */
// ----------------------------------------------------------------------------
// wsfr_pkg
// Types and constants of the WebSocket frame receiver.
// ----------------------------------------------------------------------------
package wsfr_pkg;

  // Parse phase, one-hot.
  typedef enum logic [4:0] {
    PH_HDR0 = 5'b00001,
    PH_HDR1 = 5'b00010,
    PH_EXT  = 5'b00100,
    PH_KEY  = 5'b01000,
    PH_DATA = 5'b10000
  } phase_t;

  // Event kinds on the result channel.
  localparam logic [1:0] EV_PAYLOAD     = 2'd0;
  localparam logic [1:0] EV_PONG_REQ    = 2'd1;
  localparam logic [1:0] EV_CLOSED_PEER = 2'd2;
  localparam logic [1:0] EV_CLOSED_BAD  = 2'd3;

  // Opcodes.
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  // Seven-bit length codes that announce an extended length.
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // Extended length bytes still due minus one.
  localparam logic [2:0] EXT16_CNT = 3'd1;
  localparam logic [2:0] EXT64_CNT = 3'd7;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [7:0] payload_byte;
    logic [1:0] frame_opcode;
    logic       last_of_frame;
  } result_t;

endpackage

/* design/wsfr_in_stage.sv */
// ----------------------------------------------------------------------------
// wsfr_in_stage
// Input register: holds one received byte until the parser takes it.
// ----------------------------------------------------------------------------
module wsfr_in_stage
  import wsfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  input  logic       advance,
  output logic       fire,
  output logic [7:0] byte_out
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;
  logic [7:0] byte_nxt;
  logic       load;

  assign load     = !valid_r || advance;
  assign in_stall = valid_r && !advance;
  assign fire     = valid_r && advance;
  assign byte_out = byte_r;

  always_comb begin
    valid_nxt = load ? in_valid : valid_r;
    byte_nxt  = (load && in_valid) ? in_rx_byte : byte_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

endmodule

/* design/wsfr_parser.sv */
// ----------------------------------------------------------------------------
// wsfr_parser
// Frame parser: header, extended length, masking key and payload unmasking.
// ----------------------------------------------------------------------------
module wsfr_parser
  import wsfr_pkg::*;
#(
  parameter int LENGTH_BITS = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  logic [7:0] rx_byte,
  output logic       has_result,
  output result_t    result
);

  phase_t                 phase_r, phase_nxt;
  logic [3:0]             opcode_r, opcode_nxt;
  logic                   masked_r, masked_nxt;
  logic [LENGTH_BITS-1:0] rem_r, rem_nxt;
  logic [2:0]             cnt_r, cnt_nxt;
  logic [31:0]            key_r, key_nxt;
  logic [1:0]             mpos_r, mpos_nxt;
  logic                   closed_r, closed_nxt;

  logic [3:0]             op_in;
  logic [6:0]             len7;
  logic [LENGTH_BITS-1:0] ext_len;
  logic [7:0]             key_byte;
  logic                   rem_is_one;

  assign op_in      = rx_byte[3:0];
  assign len7       = rx_byte[6:0];
  assign rem_is_one = (rem_r == LENGTH_BITS'(1));

  // A length that would overflow on the next shift saturates to all ones.
  assign ext_len = (rem_r[LENGTH_BITS-1 -: 8] != 8'd0) ? '1
                 : {rem_r[LENGTH_BITS-9:0], rx_byte};

  always_comb begin
    case (mpos_r)
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
    if (!masked_r) begin
      key_byte = 8'd0;
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    opcode_nxt = opcode_r;
    masked_nxt = masked_r;
    rem_nxt    = rem_r;
    cnt_nxt    = cnt_r;
    key_nxt    = key_r;
    mpos_nxt   = mpos_r;
    closed_nxt = closed_r;
    has_result = 1'b0;
    result     = '0;

    if (fire && !closed_r) begin
      unique case (phase_r)
        PH_HDR0: begin
          opcode_nxt = op_in;
          phase_nxt  = PH_HDR1;
          if (op_in <= OP_BINARY || op_in == OP_PONG) begin
            has_result = 1'b0;
          end else if (op_in == OP_PING) begin
            has_result        = 1'b1;
            result.event_kind = EV_PONG_REQ;
          end else begin
            closed_nxt        = 1'b1;
            has_result        = 1'b1;
            result.event_kind = (op_in == OP_CLOSE) ? EV_CLOSED_PEER : EV_CLOSED_BAD;
          end
        end
        PH_HDR1: begin
          masked_nxt = rx_byte[7];
          rem_nxt    = '0;
          if (len7 == LEN_EXT16) begin
            phase_nxt = PH_EXT;
            cnt_nxt   = EXT16_CNT;
          end else if (len7 == LEN_EXT64) begin
            phase_nxt = PH_EXT;
            cnt_nxt   = EXT64_CNT;
          end else begin
            rem_nxt  = LENGTH_BITS'(len7);
            mpos_nxt = 2'd0;
            if (rx_byte[7]) begin
              phase_nxt = PH_KEY;
              key_nxt   = '0;
            end else begin
              phase_nxt = (len7 == 7'd0) ? PH_HDR0 : PH_DATA;
            end
          end
        end
        PH_EXT: begin
          rem_nxt = ext_len;
          if (cnt_r == 3'd0) begin
            mpos_nxt = 2'd0;
            if (masked_r) begin
              phase_nxt = PH_KEY;
              key_nxt   = '0;
            end else begin
              phase_nxt = (ext_len == '0) ? PH_HDR0 : PH_DATA;
            end
          end else begin
            cnt_nxt = cnt_r - 3'd1;
          end
        end
        PH_KEY: begin
          key_nxt = {key_r[23:0], rx_byte};
          if (mpos_r == 2'd3) begin
            mpos_nxt  = 2'd0;
            phase_nxt = (rem_r == '0) ? PH_HDR0 : PH_DATA;
          end else begin
            mpos_nxt = mpos_r + 2'd1;
          end
        end
        PH_DATA: begin
          mpos_nxt = mpos_r + 2'd1;
          rem_nxt  = rem_r - LENGTH_BITS'(1);
          if (rem_is_one) begin
            phase_nxt = PH_HDR0;
          end
          // Control frame payload is skipped without a result.
          if (opcode_r <= OP_BINARY) begin
            has_result           = 1'b1;
            result.event_kind    = EV_PAYLOAD;
            result.payload_byte  = rx_byte ^ key_byte;
            result.frame_opcode  = opcode_r[1:0];
            result.last_of_frame = rem_is_one;
          end
        end
        default: begin
          phase_nxt = PH_HDR0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HDR0;
      opcode_r <= '0;
      masked_r <= 1'b0;
      rem_r    <= '0;
      cnt_r    <= '0;
      key_r    <= '0;
      mpos_r   <= '0;
      closed_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      opcode_r <= opcode_nxt;
      masked_r <= masked_nxt;
      rem_r    <= rem_nxt;
      cnt_r    <= cnt_nxt;
      key_r    <= key_nxt;
      mpos_r   <= mpos_nxt;
      closed_r <= closed_nxt;
    end
  end

endmodule

/* design/wsfr_out_stage.sv */
// ----------------------------------------------------------------------------
// wsfr_out_stage
// Result register: holds one result word until the receiver takes it.
// ----------------------------------------------------------------------------
module wsfr_out_stage
  import wsfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  result_t    result,
  output logic       advance,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_event_kind,
  output logic [7:0] out_payload_byte,
  output logic [1:0] out_frame_opcode,
  output logic       out_last_of_frame
);

  logic    valid_r, valid_nxt;
  result_t res_r, res_nxt;

  // The register can take a new word when empty or when its word leaves.
  assign advance = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = advance ? load : valid_r;
    res_nxt   = (advance && load) ? result : res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid         = valid_r;
  assign out_event_kind    = res_r.event_kind;
  assign out_payload_byte  = res_r.payload_byte;
  assign out_frame_opcode  = res_r.frame_opcode;
  assign out_last_of_frame = res_r.last_of_frame;

endmodule

/* design/websocket_frame_receiver.sv */
// ----------------------------------------------------------------------------
// websocket_frame_receiver
// Path: input register, combinational parser, result register to out_ ports.
// Throughput: one byte per cycle while the result register is not stalled;
// the parser state updates once per byte.
// A stalled result register holds the input register full, then stalls input.
// Reset (synchronous, rst_n low) clears the parser to await a frame header.
// ----------------------------------------------------------------------------
module websocket_frame_receiver
  import wsfr_pkg::*;
#(
  parameter int LENGTH_BITS = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_event_kind,
  output logic [7:0] out_payload_byte,
  output logic [1:0] out_frame_opcode,
  output logic       out_last_of_frame
);

  logic       advance;
  logic       fire;
  logic [7:0] rx_byte;
  logic       has_result;
  result_t    result;

  wsfr_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .advance    (advance),
    .fire       (fire),
    .byte_out   (rx_byte)
  );

  wsfr_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .rx_byte    (rx_byte),
    .has_result (has_result),
    .result     (result)
  );

  wsfr_out_stage u_out (
    .clk               (clk),
    .rst_n             (rst_n),
    .load              (has_result),
    .result            (result),
    .advance           (advance),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_event_kind    (out_event_kind),
    .out_payload_byte  (out_payload_byte),
    .out_frame_opcode  (out_frame_opcode),
    .out_last_of_frame (out_last_of_frame)
  );

endmodule

/* design/wsfr_checker.sv */
// ----------------------------------------------------------------------------
// wsfr_checker
// Port-level checks of the WebSocket frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wsfr_checker
  import wsfr_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] in_rx_byte,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_event_kind,
  input logic [7:0] out_payload_byte,
  input logic [1:0] out_frame_opcode,
  input logic       out_last_of_frame
);

  logic        closing;
  logic        meta_zero;
  logic        in_wait;
  logic        out_wait;
  logic        out_take;
  logic        event_word;
  logic [12:0] out_word;

  assign closing    = (out_event_kind == EV_CLOSED_PEER) || (out_event_kind == EV_CLOSED_BAD);
  assign meta_zero  = (out_payload_byte == 8'd0) && (out_frame_opcode == 2'd0)
                   && !out_last_of_frame;
  assign in_wait    = in_valid && in_stall;
  assign out_wait   = out_valid && out_stall;
  assign out_take   = out_valid && !out_stall;
  assign event_word = out_valid && (out_event_kind != EV_PAYLOAD);
  assign out_word   = {out_event_kind, out_payload_byte, out_frame_opcode, out_last_of_frame};

  `ASSERT_NEXT(a_in_hold, clk, rst_n, in_wait, in_valid && $stable(in_rx_byte), "stalled input word changed")
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_wait, out_valid, "result word dropped while stalled")
  `ASSERT_NEXT(a_out_stable, clk, rst_n, out_wait, $stable(out_word), "stalled result word changed")
  `ASSERT_NEXT(a_close_final, clk, rst_n, out_take && closing, !out_valid, "word after a closed event")
  `ASSERT_CLK(a_event_clean, clk, rst_n, !event_word || meta_zero, "event word carries payload fields")

endmodule

bind websocket_frame_receiver wsfr_checker u_wsfr_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .in_rx_byte        (in_rx_byte),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_event_kind    (out_event_kind),
  .out_payload_byte  (out_payload_byte),
  .out_frame_opcode  (out_frame_opcode),
  .out_last_of_frame (out_last_of_frame)
);
